// File: hw/rtl/mrr_pkg.sv
// Package for the Miller-Rabin round unit: width constant.
// No dependencies.
package mrr_pkg;
  localparam int unsigned MrrWidth = 62;
endpackage

// File: hw/rtl/mrr_modmul.sv
// Bit-serial modular multiplier: p = x*y mod n by double-and-add, one bit of y per cycle.
// Depends on mrr_pkg.
module mrr_modmul import mrr_pkg::*; #(
  parameter int unsigned Width = MrrWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] x_i,
  input  logic [Width-1:0] y_i,
  input  logic [Width-1:0] n_i,
  output logic             done_o,
  output logic [Width-1:0] p_o
);
  logic             run_q;
  logic [Width-1:0] x_q, y_q, acc_q;
  logic [Width:0]   sum_acc, sum_x, dif_acc, dif_x;
  logic [Width-1:0] acc_d, x_d;

  always_comb begin
    sum_acc = {1'b0, acc_q} + {1'b0, x_q};
    dif_acc = sum_acc - {1'b0, n_i};
    acc_d   = acc_q;
    if (y_q[0]) begin
      acc_d = dif_acc[Width] ? sum_acc[Width-1:0] : dif_acc[Width-1:0];
    end
    sum_x = {1'b0, x_q} + {1'b0, x_q};
    dif_x = sum_x - {1'b0, n_i};
    x_d   = dif_x[Width] ? sum_x[Width-1:0] : dif_x[Width-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (start_i) begin
      run_q <= 1'b1;
    end else if (run_q && y_q == '0) begin
      run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      y_q   <= y_i;
      acc_q <= '0;
    end else if (run_q && y_q != '0) begin
      x_q   <= x_d;
      y_q   <= y_q >> 1;
      acc_q <= acc_d;
    end
  end

  assign done_o = run_q && (y_q == '0) && !start_i;
  assign p_o    = acc_q;
endmodule

// File: hw/rtl/mrr_modred.sv
// Bit-serial restoring remainder: r = a mod d, one quotient bit per cycle.
// Depends on mrr_pkg.
module mrr_modred import mrr_pkg::*; #(
  parameter int unsigned Width = MrrWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] d_i,
  output logic             done_o,
  output logic [Width-1:0] r_o
);
  localparam int unsigned CntW = $clog2(Width + 1);
  logic [CntW-1:0]  cnt_q;
  logic             run_q;
  logic [Width-1:0] a_q, r_q;
  logic [Width:0]   sh, dif;

  always_comb begin
    sh  = {r_q, a_q[Width-1]};
    dif = sh - {1'b0, d_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= CntW'(Width);
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      r_q <= '0;
    end else if (run_q && cnt_q != '0) begin
      a_q <= a_q << 1;
      r_q <= dif[Width] ? sh[Width-1:0] : dif[Width-1:0];
    end
  end

  assign done_o = run_q && (cnt_q == '0) && !start_i;
  assign r_o    = r_q;
endmodule

// File: hw/rtl/miller_rabin_round_unit.sv
// Miller-Rabin round unit: one round per word, verdict strobed on done_o.
// Steps: factor the candidate and form the base with the bit-serial remainder, then per
// exponent bit up to two bit-serial modular multiplies, then one per squaring;
// one word at a time.
// The modular multiplier sets the rate. Reset is asynchronous, active low, and
// returns the controller to idle; the receiver cannot stall.
module miller_rabin_round_unit import mrr_pkg::*; #(
  parameter int unsigned Width = MrrWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [Width-1:0] candidate_i,
  input  logic [Width-1:0] random_word_i,
  output logic             done_o,
  output logic             verdict_o
);
  localparam logic [2:0] StIdle = 3'd0, StFact = 3'd1, StRed = 3'd2, StPowM = 3'd3,
                         StPowS = 3'd4, StSqr  = 3'd5, StOut = 3'd6;
  localparam int unsigned TW = $clog2(Width + 1);

  logic [2:0]       st_q;
  logic [Width-1:0] n_q, u_q, rw_q, r_q, b_q, prev_q;
  logic [TW-1:0]    t_q;
  logic             mul_go_q, red_go_q, ver_q, pm_q;
  logic             mul_done, red_done;
  logic [Width-1:0] mul_x, mul_y, mul_p, red_r, nm1;

  assign nm1 = n_q - 1'b1;

  mrr_modred #(.Width(Width)) u_red (
    .clk_i, .rst_ni, .start_i(red_go_q), .a_i(rw_q), .d_i(nm1),
    .done_o(red_done), .r_o(red_r)
  );

  always_comb begin
    mul_x = r_q;
    mul_y = b_q;
    if (st_q == StPowS) begin
      mul_x = b_q;
    end else if (st_q == StSqr) begin
      mul_x = r_q;
      mul_y = r_q;
    end
  end

  mrr_modmul #(.Width(Width)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_go_q), .x_i(mul_x), .y_i(mul_y), .n_i(n_q),
    .done_o(mul_done), .p_o(mul_p)
  );

  assign busy = (st_q != StIdle);
  assign done_o = (st_q == StOut);
  assign verdict_o = ver_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      mul_go_q <= 1'b0;
      red_go_q <= 1'b0;
      ver_q <= 1'b0;
      pm_q <= 1'b0;
      n_q <= '0;
      u_q <= '0;
      rw_q <= '0;
      r_q <= '0;
      b_q <= '0;
      prev_q <= '0;
      t_q <= '0;
    end else begin
      mul_go_q <= 1'b0;
      red_go_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (start) begin
            n_q  <= candidate_i;
            rw_q <= random_word_i;
            if (candidate_i == Width'(2)) begin
              ver_q <= 1'b1;
              st_q <= StOut;
            end else if (candidate_i < Width'(2) || !candidate_i[0]) begin
              ver_q <= 1'b0;
              st_q <= StOut;
            end else begin
              u_q <= candidate_i - 1'b1;
              t_q <= '0;
              st_q <= StFact;
            end
          end
        end
        StFact: begin
          if (!u_q[0]) begin
            u_q <= u_q >> 1;
            t_q <= t_q + 1'b1;
          end else begin
            red_go_q <= 1'b1;
            st_q <= StRed;
          end
        end
        StRed: begin
          if (red_done) begin
            b_q <= red_r + 1'b1;
            r_q <= Width'(1);
            st_q <= StPowM;
            pm_q <= 1'b0;
          end
        end
        StPowM: begin
          if (u_q == '0) begin
            prev_q <= r_q;
            if (t_q == '0) begin
              ver_q <= (r_q == Width'(1));
              st_q <= StOut;
            end else begin
              mul_go_q <= 1'b1;
              st_q <= StSqr;
            end
          end else if (!pm_q) begin
            if (u_q[0]) begin
              mul_go_q <= 1'b1;
              pm_q <= 1'b1;
            end else begin
              mul_go_q <= 1'b1;
              st_q <= StPowS;
            end
          end else if (mul_done) begin
            r_q <= mul_p;
            pm_q <= 1'b0;
            mul_go_q <= 1'b1;
            st_q <= StPowS;
          end
        end
        StPowS: begin
          if (mul_done) begin
            b_q <= mul_p;
            u_q <= u_q >> 1;
            st_q <= StPowM;
          end
        end
        StSqr: begin
          if (mul_done) begin
            r_q <= mul_p;
            t_q <= t_q - 1'b1;
            if (mul_p == Width'(1) && prev_q != Width'(1) && prev_q != nm1) begin
              ver_q <= 1'b0;
              st_q <= StOut;
            end else if (t_q == TW'(1)) begin
              ver_q <= (mul_p == Width'(1));
              st_q <= StOut;
            end else begin
              prev_q <= mul_p;
              mul_go_q <= 1'b1;
            end
          end
        end
        StOut: st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

// File: test/miller_rabin_round_unit_test.sv
// Testbench for the Miller-Rabin round unit: directed and random words checked
// against a behavioral primality-round predictor. Depends on mrr_pkg and the unit.
module miller_rabin_round_unit_test;
  import mrr_pkg::*;

  localparam int unsigned W = MrrWidth;
  typedef logic [W-1:0] word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  word_t candidate_i = '0;
  word_t random_word_i = '0;
  logic done_o;
  logic verdict_o;

  bit verdict_q[$];
  int unsigned errors = 0;
  int unsigned idle_pct = 0;

  miller_rabin_round_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .candidate_i(candidate_i), .random_word_i(random_word_i),
    .done_o(done_o), .verdict_o(verdict_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] addm(logic [63:0] x, logic [63:0] y, logic [63:0] n);
    logic [63:0] s;
    s = x + y;
    if (s >= n) s = s - n;
    return s;
  endfunction

  function automatic logic [63:0] mulm(logic [63:0] x, logic [63:0] y, logic [63:0] n);
    logic [63:0] acc;
    acc = 0;
    x = x % n;
    y = y % n;
    while (y != 0) begin
      if (y[0]) acc = addm(acc, x, n);
      y = y >> 1;
      x = addm(x, x, n);
    end
    return acc;
  endfunction

  function automatic bit round_verdict(word_t cand, word_t rw);
    logic [63:0] n, d, a, x, b, e, prev;
    int unsigned t;
    bit comp;
    n = 64'(cand);
    if (n == 2) return 1'b1;
    if (n <= 1 || !n[0]) return 1'b0;
    d = n - 1;
    t = 0;
    while (!d[0]) begin
      d = d >> 1;
      t++;
    end
    a = (64'(rw) % (n - 1)) + 1;
    x = 1;
    b = a % n;
    e = d;
    while (e != 0) begin
      if (e[0]) x = mulm(x, b, n);
      e = e >> 1;
      b = mulm(b, b, n);
    end
    prev = x;
    comp = 1'b0;
    for (int i = 0; i < t; i++) begin
      x = mulm(x, x, n);
      if (x == 1 && prev != 1 && prev != n - 1) begin
        comp = 1'b1;
        break;
      end
      prev = x;
    end
    if (!comp && x != 1) comp = 1'b1;
    return !comp;
  endfunction

  task automatic report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task automatic send_word(word_t cand, word_t rw);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    start <= 1'b1;
    candidate_i <= cand;
    random_word_i <= rw;
    verdict_q.push_back(round_verdict(cand, rw));
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (verdict_q.size() == 0) report("verdict with none expected");
      else begin
        bit exp_v;
        exp_v = verdict_q.pop_front();
        if (verdict_o !== exp_v)
          report($sformatf("verdict %b expected %b", verdict_o, exp_v));
      end
    end
  end

  function automatic word_t rand_word();
    return word_t'({$urandom(), $urandom()});
  endfunction

  task automatic test_special_cases();
    send_word(0, rand_word());
    send_word(1, rand_word());
    send_word(2, rand_word());
    send_word(2, '1);
    send_word(4, 0);
    send_word('1 - 1, rand_word());
    send_word(3, 0);
    send_word(3, '1);
    send_word(5, 3);
    send_word(9, 7);
    send_word(561, 1);
    send_word(97, '0);
  endtask

  task automatic test_extremes();
    send_word('1, '1);
    send_word('1, '0);
    send_word(62'h3FFFFFFFFFFFFFC7, rand_word());
    send_word(62'h3FFFFFFFFFFFFFC7, '1);
    send_word(62'h2000000000000001, rand_word());
    send_word({1'b1, {(W-1){1'b0}}} + 1, '1);
    send_word(62'h15555555AAAAAAAB, 62'h2AAAAAAA55555555);
  endtask

  task automatic test_random(int unsigned count, int unsigned pct);
    word_t c;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      c = rand_word();
      case ($urandom_range(3))
        0: c = c >> $urandom_range(W - 1);
        1: c[0] = 1'b1;
        2: c = (c >> $urandom_range(50, 30)) | 1;
        default: ;
      endcase
      send_word(c, rand_word() >> $urandom_range(W - 1));
    end
    idle_pct = 0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_extremes();
    test_random(30, 0);
    test_random(30, 87);
    test_random(40, 8);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("[miller_rabin_round_unit] OK");
    else $display("[miller_rabin_round_unit] ERROR");
    $finish;
  end

  initial begin
    #200000000;
    $display("[miller_rabin_round_unit] ERROR");
    $finish;
  end
endmodule
